>>> design/rv32s_pkg.sv
package rv32s_pkg;

    // Byte memory geometry: four byte lanes, each 2^ROW_BITS rows deep
    localparam int MEM_ADDR_BITS = 16;
    localparam int ROW_BITS      = MEM_ADDR_BITS - 2;
    localparam int ROWS          = 1 << ROW_BITS;
    localparam int LANES         = 4;

    localparam logic [31:0] MEM_SIZE    = 32'h1 << MEM_ADDR_BITS;
    localparam logic [31:0] MEM_BASE    = 32'h8000_0000;
    localparam logic [31:0] UART_ADDR   = 32'h1000_0004;
    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [31:0] LUI_MASK    = 32'hFFFF_F000;

    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;

    localparam logic OP_LOAD_IMAGE = 1'b0;
    localparam logic OP_EXECUTE    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEC,
        ST_EXE,
        ST_WB
    } state_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_WORD,
        LD_BYTE,
        LD_UART_WORD,
        LD_UART_BYTE
    } ld_kind_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] load_offset;
        logic [7:0]  load_byte;
        logic [31:0] uart_word;
        logic [4:0]  reg_index;
    } item_t;

    typedef struct packed {
        logic [31:0] exec_pc;
        logic [31:0] instruction;
        logic [31:0] next_pc;
        logic        wrote_reg;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        ebreak_seen;
        logic [31:0] selected_value;
    } result_t;

endpackage

>>> design/rv32s_item_if.sv
interface rv32s_item_if;
    import rv32s_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/rv32s_result_if.sv
interface rv32s_result_if;
    import rv32s_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/rv32_subset_instruction_step.sv
// Small RV32 core (addi, add, lui, jalr, lw, lbu, sw, sb, ebreak) stepped one beat at a time.
// A beat either writes one image byte into the byte memory at 0x80000000 + load_offset, or
// fetches and executes the instruction at the PC; every beat returns one result beat.
// After acceptance each beat passes through decode, execute and write-back to its result register;
// fetch from the four byte-lane memories, register file read, then data memory access, each
// through a synchronous read. The next beat is accepted in the cycle the previous one writes back.
// A stalled result holds the block in write-back.
// The byte memory has no reset and must be loaded before it is fetched or read. The register
// file reads as zero after reset (per-entry valid bits); x0 always reads zero. There is no
// clearing pass.
module rv32_subset_instruction_step (
    input  logic           clk,
    input  logic           rst_n,
    rv32s_item_if.sink     item,
    rv32s_result_if.source result
);
    import rv32s_pkg::*;

    function automatic logic [ROW_BITS-1:0] lane_row(input logic [MEM_ADDR_BITS-1:0] off,
                                                     input logic [1:0] lane);
        return off[MEM_ADDR_BITS-1:2] + ROW_BITS'(lane < off[1:0]);
    endfunction

    function automatic logic [31:0] gather(input logic [LANES-1:0][7:0] q, input logic [1:0] lo);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < LANES; i++)
        begin
            w[8*i +: 8] = q[lo + 2'(i)];
        end
        return w;
    endfunction

    // control
    state_t state_reg, state_next;
    logic   accept, out_free, wb_go;

    // architectural PC
    logic [31:0] pc_reg, pc_next;

    // per-beat context
    logic        op_reg;
    logic [31:0] uart_reg;
    logic [4:0]  sel_reg;
    logic [1:0]  lo_reg;
    logic [31:0] exec_pc_reg;
    logic [31:0] instr_reg;

    // execute results
    logic        wr_reg;
    logic [4:0]  rd_reg;
    logic [31:0] val_reg;
    ld_kind_t    ld_kind_reg;
    logic [1:0]  ld_lo_reg;
    logic        ebreak_reg;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // byte lanes
    logic [7:0]                       bank_mem [LANES][ROWS];
    logic [LANES-1:0]                 bank_rd, bank_wr;
    logic [LANES-1:0][ROW_BITS-1:0]   bank_row;
    logic [LANES-1:0][7:0]            bank_wdata;
    logic [LANES-1:0][7:0]            bank_q;

    // register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] rf_q_a, rf_q_b;
    logic [4:0]  rf_addr_a, rf_addr_b;
    logic        rf_en_a, rf_en_b, rf_we;

    // image load
    logic [31:0] img_off;
    logic        img_in_range;

    // decode / execute
    logic [31:0] word_dec;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_s, sum_i, data_addr, pc_plus4;
    logic [MEM_ADDR_BITS-1:0] data_off;
    logic        byte_ok, word_ok, exe_active;
    logic        exe_wr, exe_ebreak, st_word, st_byte;
    logic [31:0] exe_val, exe_next;
    ld_kind_t    exe_ld;

    // write-back
    logic [31:0] wb_val, sel_val;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || result.ready;
    assign accept   = item.valid && item.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC: state_next = ST_EXE;
            ST_EXE: state_next = ST_WB;
            ST_WB:
            begin
                if (wb_go)
                begin
                    state_next = accept ? ST_DEC : ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        item.ready = (state_reg == ST_IDLE) || ((state_reg == ST_WB) && out_free);
        wb_go      = (state_reg == ST_WB) && out_free;
        exe_active = (state_reg == ST_EXE) && (op_reg == OP_EXECUTE);
        rf_en_a    = (state_reg == ST_DEC) || (state_reg == ST_EXE);
        rf_en_b    = (state_reg == ST_DEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= MEM_BASE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // byte lanes: fetch and image writes at accept, data access in execute
    // ------------------------------------------------------------------
    assign img_off      = {16'h0000, item.payload.load_offset};
    assign img_in_range = img_off < MEM_SIZE;

    always_comb
    begin
        bank_rd = '0;
        bank_wr = '0;
        for (int l = 0; l < LANES; l++)
        begin
            bank_row[l]   = lane_row(pc_reg[MEM_ADDR_BITS-1:0], 2'(l));
            bank_wdata[l] = item.payload.load_byte;
        end
        if (accept)
        begin
            if (item.payload.operation == OP_EXECUTE)
            begin
                bank_rd = '1;
            end
            else if (img_in_range)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    bank_row[l] = img_off[MEM_ADDR_BITS-1:2];
                    bank_wr[l]  = (img_off[1:0] == 2'(l));
                end
            end
        end
        else if (exe_active)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                bank_row[l]   = lane_row(data_off, 2'(l));
                // byte of rs2 that lands on this lane, modulo 4
                bank_wdata[l] = rf_q_b[8 * 2'(2'(l) - data_off[1:0]) +: 8];
                bank_rd[l]    = (exe_ld == LD_WORD) || (exe_ld == LD_BYTE);
                bank_wr[l]    = st_word || (st_byte && (data_off[1:0] == 2'(l)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (bank_wr[l])
            begin
                bank_mem[l][bank_row[l]] <= bank_wdata[l];
            end
            if (bank_rd[l])
            begin
                bank_q[l] <= bank_mem[l][bank_row[l]];
            end
        end
    end

    // ------------------------------------------------------------------
    // beat context captured at accept; the fetched instruction is captured in decode
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= item.payload.operation;
            uart_reg    <= item.payload.uart_word;
            sel_reg     <= item.payload.reg_index;
            lo_reg      <= pc_reg[1:0];
            exec_pc_reg <= (item.payload.operation == OP_EXECUTE) ? pc_reg : '0;
        end
        if (state_reg == ST_DEC)
        begin
            instr_reg <= (op_reg == OP_EXECUTE) ? word_dec : '0;
        end
    end

    assign word_dec = gather(bank_q, lo_reg);

    // ------------------------------------------------------------------
    // register file: rs1/rs2 in decode, selected register on port A in execute
    // ------------------------------------------------------------------
    assign rf_addr_a = (state_reg == ST_DEC) ? word_dec[19:15] : sel_reg;
    assign rf_addr_b = word_dec[24:20];
    assign rf_we     = wb_go && wr_reg;

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rd_reg] <= wb_val;
        end
        if (rf_en_a)
        begin
            rf_q_a <= rf_valid_reg[rf_addr_a] ? rf_mem[rf_addr_a] : '0;
        end
        if (rf_en_b)
        begin
            rf_q_b <= rf_valid_reg[rf_addr_b] ? rf_mem[rf_addr_b] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[rd_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // execute
    // ------------------------------------------------------------------
    assign opc      = instr_reg[6:0];
    assign f3       = instr_reg[14:12];
    assign rd       = instr_reg[11:7];
    assign imm_i    = {{20{instr_reg[31]}}, instr_reg[31:20]};
    assign imm_s    = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
    assign sum_i    = rf_q_a + imm_i;
    assign pc_plus4 = exec_pc_reg + 32'd4;
    assign data_addr = (opc == OPC_STORE) ? (rf_q_a + imm_s) : sum_i;
    assign data_off  = data_addr[MEM_ADDR_BITS-1:0];

    // wholly inside memory; a word must not run past the top
    assign byte_ok = data_addr[31] && (data_addr[30:MEM_ADDR_BITS] == '0);
    assign word_ok = byte_ok && !((&data_addr[MEM_ADDR_BITS-1:2]) && (data_addr[1:0] != 2'b00));

    always_comb
    begin
        exe_wr     = 1'b0;
        exe_val    = '0;
        exe_ld     = LD_NONE;
        exe_next   = pc_plus4;
        exe_ebreak = 1'b0;
        st_word    = 1'b0;
        st_byte    = 1'b0;
        unique case (opc)
            OPC_OP_IMM:
            begin
                if (f3 == F3_ADD)
                begin
                    exe_wr  = 1'b1;
                    exe_val = sum_i;
                end
            end
            OPC_JALR:
            begin
                if (f3 == F3_ADD)
                begin
                    exe_next = {sum_i[31:1], 1'b0};
                    exe_wr   = 1'b1;
                    exe_val  = pc_plus4;
                end
            end
            OPC_OP:
            begin
                if (f3 == F3_ADD)
                begin
                    exe_wr  = 1'b1;
                    exe_val = rf_q_a + rf_q_b;
                end
            end
            OPC_LUI:
            begin
                exe_wr  = 1'b1;
                exe_val = instr_reg & LUI_MASK;
            end
            OPC_LOAD:
            begin
                if (f3 == F3_WORD)
                begin
                    if (data_addr == UART_ADDR)
                    begin
                        exe_wr = 1'b1;
                        exe_ld = LD_UART_WORD;
                    end
                    else if (word_ok)
                    begin
                        exe_wr = 1'b1;
                        exe_ld = LD_WORD;
                    end
                end
                else if (f3 == F3_BYTE_U)
                begin
                    if (data_addr == UART_ADDR)
                    begin
                        exe_wr = 1'b1;
                        exe_ld = LD_UART_BYTE;
                    end
                    else if (byte_ok)
                    begin
                        exe_wr = 1'b1;
                        exe_ld = LD_BYTE;
                    end
                end
            end
            OPC_STORE:
            begin
                if (f3 == F3_WORD)
                begin
                    st_word = word_ok;
                end
                else if (f3 == F3_BYTE)
                begin
                    st_byte = byte_ok;
                end
            end
            OPC_SYSTEM:
            begin
                exe_ebreak = (instr_reg == EBREAK_WORD);
            end
            default:
            begin
            end
        endcase
    end

    assign pc_next = exe_active ? exe_next : pc_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXE)
        begin
            wr_reg      <= exe_wr && (rd != 5'd0);
            rd_reg      <= rd;
            val_reg     <= exe_val;
            ld_kind_reg <= exe_ld;
            ld_lo_reg   <= data_off[1:0];
            ebreak_reg  <= exe_ebreak;
        end
    end

    // ------------------------------------------------------------------
    // write-back and result
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (ld_kind_reg)
            LD_WORD:      wb_val = gather(bank_q, ld_lo_reg);
            LD_BYTE:      wb_val = {24'h000000, bank_q[ld_lo_reg]};
            LD_UART_WORD: wb_val = uart_reg;
            LD_UART_BYTE: wb_val = {24'h000000, uart_reg[7:0]};
            default:      wb_val = val_reg;
        endcase
    end

    // selected register was read before this beat's own write
    assign sel_val = (wr_reg && (sel_reg == rd_reg)) ? wb_val : rf_q_a;

    always_comb
    begin
        out_data_next                = out_data_reg;
        out_valid_next               = out_valid_reg && !result.ready;
        if (wb_go)
        begin
            out_valid_next               = 1'b1;
            out_data_next.exec_pc        = exec_pc_reg;
            out_data_next.instruction    = instr_reg;
            out_data_next.next_pc        = pc_reg;
            out_data_next.wrote_reg      = wr_reg;
            out_data_next.dest_index     = wr_reg ? rd_reg : 5'd0;
            out_data_next.dest_value     = wr_reg ? wb_val : '0;
            out_data_next.ebreak_seen    = ebreak_reg;
            out_data_next.selected_value = sel_val;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

endmodule

>>> design/rv32s_checker.sv
module rv32s_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input rv32s_pkg::result_t  result_payload
);
    import rv32s_pkg::*;

    // decode and execute cycles follow every accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready ##1 !item_ready)
        else $error("item accepted during decode/execute");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_payload))
        else $error("stalled result beat changed");

    a_dest_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_payload.wrote_reg ? (result_payload.dest_index != 5'd0)
                          : ((result_payload.dest_index == 5'd0)
                             && (result_payload.dest_value == 32'd0))))
        else $error("write-back fields inconsistent");

    a_ebreak: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_payload.ebreak_seen |->
            (result_payload.instruction == EBREAK_WORD) && !result_payload.wrote_reg)
        else $error("ebreak flagged on wrong instruction");

endmodule

bind rv32_subset_instruction_step rv32s_checker u_rv32s_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);
